/* hdl/fcas_pkg.sv */
`default_nettype none

package fcas_pkg;

    // Widths fixed by the pixel and result formats
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned FP_W     = 25;
    localparam int unsigned CTRL_W   = 2;
    localparam int unsigned ENTRY_W  = 3 * CHAN_W;

    // Configuration reset and fixed divisors
    localparam logic [FP_W-1:0]   FP_RESET = 25'd2073600;
    localparam logic [FP_W-1:0]   FP_ONE   = 25'd1;
    localparam logic [FP_W-1:0]   CUBE_DIV = 25'd65025;

    // Divide a cube (below 2^24) by 255*255 as (x * CUBE_RECIP) >> CUBE_SHIFT, exact
    localparam logic [24:0]       CUBE_RECIP = 25'd16909061;
    localparam int unsigned       CUBE_SHIFT = 40;

    // Control codes on the result
    localparam logic [CTRL_W-1:0] CTRL_OFF = 2'd0;
    localparam logic [CTRL_W-1:0] CTRL_ON  = 2'd2;

    // Channel selectors
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } frame_sums_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [FP_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_HIST_WR,
        ST_ACC,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_SQUARE,
        ST_CUBE,
        ST_SCALE,
        ST_EMIT
    } back_state_t;

    // Pick one channel byte out of a history entry (red high, blue low)
    function automatic logic [CHAN_W-1:0] chan_byte(input logic [ENTRY_W-1:0] entry,
                                                    input logic [1:0] ch);
        logic [CHAN_W-1:0] b;
        unique case (ch)
            CH_RED:   b = entry[23:16];
            CH_GREEN: b = entry[15:8];
            CH_BLUE:  b = entry[7:0];
            default:  b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* hdl/frame_color_average_smoother_core.sv */
`default_nettype none

// Channel   Dir  Payload
// s_        in   tdata: red[7:0] green[15:8] blue[23:16]; tlast: frame end
// m_        out  tdata: red[7:0] green[15:8] blue[23:16] control[25:24]
// cfg_      in   data: frame pixel count, 25 bits
//
// Pixels are taken one per clock; the last pixel of a frame pushes the
// three channel sums into a two-entry queue toward the back end.
// The back end is paced by the shared one-bit-per-cycle divider (six
// divisions per frame). Input stalls only while the queue holds two
// frames; output stalls only hold the back end. Reset is synchronous
// and clears sums and history count.
module frame_color_average_smoother_core #(
    parameter int unsigned HISTORY_DEPTH = 6
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red, green, blue
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // red, green, blue, control, zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [24:0] cfg_data
);
    import fcas_pkg::*;

    logic [FP_W-1:0] frame_pixels_reg;
    logic [FP_W-1:0] divisor;
    frame_sums_t     q_wdata, q_rdata;
    logic            q_push, q_pop, q_full, q_empty;
    div_req_t        div_req;
    div_rsp_t        div_rsp;

    // Frame pixel count register; zero divides as one
    assign cfg_ready = 1'b1;
    assign divisor   = (frame_pixels_reg == '0) ? FP_ONE : frame_pixels_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pixels_reg <= FP_RESET;
        end else if (cfg_valid) begin
            frame_pixels_reg <= cfg_data;
        end
    end

    fcas_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    fcas_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    fcas_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    fcas_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rdata  (q_rdata),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .divisor  (divisor),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

/* hdl/fcas_front.sv */
`default_nettype none

module fcas_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 q_full,
    output logic                      q_push,
    output fcas_pkg::frame_sums_t     q_wdata
);
    import fcas_pkg::*;

    logic [SUM_W-1:0] red_sum_reg, green_sum_reg, blue_sum_reg;
    logic [SUM_W-1:0] red_sum_next, green_sum_next, blue_sum_next;
    logic             accept;

    // Stall only when the queue to the back end has no room
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Add this pixel into the running sums (wrap modulo 2^32)
    always_comb begin
        red_sum_next   = red_sum_reg   + SUM_W'(s_tdata[7:0]);
        green_sum_next = green_sum_reg + SUM_W'(s_tdata[15:8]);
        blue_sum_next  = blue_sum_reg  + SUM_W'(s_tdata[23:16]);
    end

    // Hand the finished frame sums to the back end
    assign q_push        = accept && s_tlast;
    assign q_wdata.red   = red_sum_next;
    assign q_wdata.green = green_sum_next;
    assign q_wdata.blue  = blue_sum_next;

    // Hold the sums, clear them after the last pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_sum_reg   <= '0;
            green_sum_reg <= '0;
            blue_sum_reg  <= '0;
        end else if (accept) begin
            if (s_tlast) begin
                red_sum_reg   <= '0;
                green_sum_reg <= '0;
                blue_sum_reg  <= '0;
            end else begin
                red_sum_reg   <= red_sum_next;
                green_sum_reg <= green_sum_next;
                blue_sum_reg  <= blue_sum_next;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/fcas_fifo.sv */
`default_nettype none

module fcas_fifo (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire fcas_pkg::frame_sums_t wdata,
    input  wire logic                 pop,
    output fcas_pkg::frame_sums_t     rdata,
    output logic                      full,
    output logic                      empty
);
    import fcas_pkg::*;

    frame_sums_t entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    // Store pushed frame sums
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/fcas_div.sv */
`default_nettype none

module fcas_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire fcas_pkg::div_req_t req,
    output fcas_pkg::div_rsp_t     rsp
);
    import fcas_pkg::*;

    localparam int unsigned CNT_W = $clog2(SUM_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SUM_W - 1);

    logic             busy_reg, done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] quo_reg;
    logic [FP_W-1:0]  rem_reg, rem_next;
    logic [FP_W-1:0]  dsr_reg;
    logic [FP_W:0]    trial;
    logic [FP_W:0]    diff;
    logic             bit_next;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        bit_next = (trial >= {1'b0, dsr_reg});
        rem_next = bit_next ? diff[FP_W-1:0] : trial[FP_W-1:0];
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    // Load on start, then one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg && req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath of the divider
    always_ff @(posedge aclk) begin
        if (!busy_reg && req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[SUM_W-2:0], bit_next};
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/fcas_back.sv */
`default_nettype none

module fcas_back #(
    parameter int unsigned HISTORY_DEPTH = 6
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire fcas_pkg::frame_sums_t q_rdata,
    input  wire logic                  q_empty,
    output logic                       q_pop,
    input  wire logic [24:0]           divisor,
    output fcas_pkg::div_req_t         div_req,
    input  wire fcas_pkg::div_rsp_t    div_rsp,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata
);
    import fcas_pkg::*;

    localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned TW = CHAN_W + FW;
    localparam logic [SW-1:0] SLOT_LAST = SW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0] FILL_MAX  = FW'(HISTORY_DEPTH);

    back_state_t       state_reg, state_next;

    logic [SUM_W-1:0]  sum_reg   [3];
    logic [CHAN_W-1:0] mean_reg  [3];
    logic [CHAN_W-1:0] level_reg [3];
    logic [ENTRY_W-1:0] hist_mem [HISTORY_DEPTH];

    logic [1:0]        ch_reg;
    logic [FW-1:0]     fill_reg;
    logic [SW-1:0]     slot_reg;
    logic [SW-1:0]     idx_reg;
    logic [TW-1:0]     total_reg;
    logic [CHAN_W-1:0] avg_reg;
    logic [15:0]       sq_reg;
    logic [23:0]       cube_reg;
    logic              nz_reg;
    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;

    logic              last_ch;
    logic              last_idx;
    logic              out_free;
    logic [CHAN_W-1:0] mean_sat;
    logic [48:0]       scaled;

    assign last_ch  = (ch_reg == CH_BLUE);
    assign last_idx = ((FW'(idx_reg) + FW'(1)) == fill_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign mean_sat = (|div_rsp.quotient[SUM_W-1:CHAN_W]) ? '1
                                                          : div_rsp.quotient[CHAN_W-1:0];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Scale the cube down by 255*255 with a reciprocal multiply
    assign scaled = 49'(cube_reg) * 49'(CUBE_RECIP);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (!q_empty) state_next = ST_MEAN_GO;
            ST_MEAN_GO:   state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT: if (div_rsp.done) state_next = last_ch ? ST_HIST_WR : ST_MEAN_GO;
            ST_HIST_WR:   state_next = ST_ACC;
            ST_ACC:       if (last_idx) state_next = ST_AVG_GO;
            ST_AVG_GO:    state_next = ST_AVG_WAIT;
            ST_AVG_WAIT:  if (div_rsp.done) state_next = ST_SQUARE;
            ST_SQUARE:    state_next = ST_CUBE;
            ST_CUBE:      state_next = ST_SCALE;
            ST_SCALE:     state_next = last_ch ? ST_EMIT : ST_ACC;
            ST_EMIT:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Queue pop and divider requests
    always_comb begin
        q_pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = sum_reg[ch_reg];
        div_req.divisor  = divisor;
        unique case (state_reg)
            ST_IDLE: begin
                q_pop = !q_empty;
            end
            ST_MEAN_GO: begin
                div_req.start = 1'b1;
            end
            ST_AVG_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = SUM_W'(total_reg);
                div_req.divisor  = FP_W'(fill_reg);
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    // History store, written once per frame
    always_ff @(posedge aclk) begin
        if (state_reg == ST_HIST_WR) begin
            hist_mem[slot_reg] <= {mean_reg[0], mean_reg[1], mean_reg[2]};
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ch_reg       <= CH_RED;
            fill_reg     <= '0;
            slot_reg     <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Raise valid when the item is loaded, drop it once taken
            if (state_reg == ST_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    ch_reg <= CH_RED;
                end
                ST_MEAN_WAIT: begin
                    if (div_rsp.done) begin
                        ch_reg <= last_ch ? CH_RED : ch_reg + 2'd1;
                    end
                end
                ST_HIST_WR: begin
                    idx_reg  <= '0;
                    slot_reg <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + SW'(1);
                    if (fill_reg != FILL_MAX) begin
                        fill_reg <= fill_reg + FW'(1);
                    end
                end
                ST_ACC: begin
                    idx_reg <= idx_reg + SW'(1);
                end
                ST_SCALE: begin
                    ch_reg  <= last_ch ? CH_RED : ch_reg + 2'd1;
                    idx_reg <= '0;
                end
                default: begin
                    ch_reg <= ch_reg;
                end
            endcase
        end
    end

    // Datapath: means, running total, cube, output item
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                sum_reg[0] <= q_rdata.red;
                sum_reg[1] <= q_rdata.green;
                sum_reg[2] <= q_rdata.blue;
                nz_reg     <= 1'b0;
            end
            ST_MEAN_WAIT: begin
                if (div_rsp.done) begin
                    mean_reg[ch_reg] <= mean_sat;
                end
            end
            ST_HIST_WR: begin
                total_reg <= '0;
            end
            ST_ACC: begin
                total_reg <= total_reg + TW'(chan_byte(hist_mem[idx_reg], ch_reg));
            end
            ST_AVG_WAIT: begin
                if (div_rsp.done) begin
                    avg_reg <= div_rsp.quotient[CHAN_W-1:0];
                    if (div_rsp.quotient[CHAN_W-1:0] != '0) begin
                        nz_reg <= 1'b1;
                    end
                end
            end
            ST_SQUARE: begin
                sq_reg <= avg_reg * avg_reg;
            end
            ST_CUBE: begin
                cube_reg <= sq_reg * 24'(avg_reg);
            end
            ST_SCALE: begin
                level_reg[ch_reg] <= scaled[CUBE_SHIFT +: CHAN_W];
                total_reg         <= '0;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tdata_reg <= {6'b0, (nz_reg ? CTRL_ON : CTRL_OFF),
                                    level_reg[2], level_reg[1], level_reg[0]};
                end
            end
            default: begin
                avg_reg <= avg_reg;
            end
        endcase
    end

endmodule

`default_nettype wire
